// ===== hw/rtl/ace_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ace_pkg
// shared constants, codes and the color table of the escape parser
// ----------------------------------------------------------------------------
package ace_pkg;

  localparam int CHAR_W   = 8;
  localparam int RGB_W    = 24;
  localparam int ACT_W    = 2;
  localparam int CODE_W   = 3;
  localparam int OUT_BITS = 1 + ACT_W + 2 * RGB_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // register indexes
  localparam logic REG_DEFAULT_FG = 1'b0;
  localparam logic REG_DEFAULT_BG = 1'b1;

  localparam logic [RGB_W-1:0] RST_DEFAULT_FG = 24'hFFFFFF;
  localparam logic [RGB_W-1:0] RST_DEFAULT_BG = 24'h000000;

  // action codes
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPLY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // color codes
  localparam logic [CODE_W-1:0] CODE_BLACK   = 3'd0;
  localparam logic [CODE_W-1:0] CODE_RED     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_GREEN   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_YELLOW  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_BLUE    = 3'd4;
  localparam logic [CODE_W-1:0] CODE_MAGENTA = 3'd5;
  localparam logic [CODE_W-1:0] CODE_RESET   = 3'd6;
  localparam logic [CODE_W-1:0] CODE_NONE    = 3'd7;

  // characters
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_J     = 8'h4A;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
  localparam logic [CHAR_W-1:0] CH_THREE = 8'h33;
  localparam logic [CHAR_W-1:0] CH_FOUR  = 8'h34;
  localparam logic [CHAR_W-1:0] CH_FIVE  = 8'h35;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_NULL  = 8'h00;

  function automatic logic [RGB_W-1:0] code_to_rgb(input logic [CODE_W-1:0] code,
                                                   input logic [RGB_W-1:0] dflt);
    logic [RGB_W-1:0] rgb;
    unique case (code)
      CODE_BLACK:   rgb = 24'h000000;
      CODE_RED:     rgb = 24'hFF0000;
      CODE_GREEN:   rgb = 24'h50C878;
      CODE_YELLOW:  rgb = 24'hFFD700;
      CODE_BLUE:    rgb = 24'h6495ED;
      CODE_MAGENTA: rgb = 24'hFF00FF;
      default:      rgb = dflt;
    endcase
    return rgb;
  endfunction

endpackage

// ===== hw/rtl/ansi_color_escape_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_color_escape_parser_top
// escape sequence parser for clear-screen and sgr color commands
//
// in_* carries one character byte per transfer in in_tdata. every accepted
// byte produces exactly one result transfer on out_*: escape flag, action
// (none, apply colors, clear screen) and the foreground and background rgb.
// the result of a byte is registered: it sits in the output register the
// cycle after its transfer. throughput is one byte per cycle while the
// receiver takes results; the only loop is the parser state update.
// in_tready is high while the output register is empty or being taken, so
// a stalled receiver holds the result and back-pressures the input after
// one byte; nothing is lost or repeated.
// the cfg_* apb port holds the default fg rgb (addr 0) and bg rgb (addr 4)
// used for reset colors; write only while idle.
// synchronous reset: parser to await, colors to none, defaults to white
// foreground and black background, output register empty.
// ----------------------------------------------------------------------------
module ansi_color_escape_parser_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [7:0] char_in
  input  logic [ace_pkg::CHAR_W-1:0]   in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [0] escape_flag, [2:1] action, [26:3] fg_rgb, [50:27] bg_rgb, rest zero
  output logic [ace_pkg::OUT_W-1:0]    out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ace_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [ace_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [ace_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import ace_pkg::*;

  typedef enum logic [2:0] {
    PH_AWAIT,
    PH_ESC,
    PH_BRACKET,
    PH_DIGIT,
    PH_BACKGROUND
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [CHAR_W-1:0]   held_r, held_nxt;
  logic [CODE_W-1:0]   fg_code_r, fg_code_nxt;
  logic [CODE_W-1:0]   bg_code_r, bg_code_nxt;
  logic [RGB_W-1:0]    def_fg_r, def_bg_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic                in_fire;
  logic                cfg_wr;
  logic                want_apply;
  logic                flag;
  logic [ACT_W-1:0]    act;
  logic [RGB_W-1:0]    fg_rgb, bg_rgb;
  logic [CHAR_W-1:0]   c;
  logic                c_dec, c_low;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    if (cfg_paddr[2] == REG_DEFAULT_BG) begin
      cfg_prdata = {{(CFG_DW-RGB_W){1'b0}}, def_bg_r};
    end else begin
      cfg_prdata = {{(CFG_DW-RGB_W){1'b0}}, def_fg_r};
    end
  end

  assign c     = in_tdata;
  assign c_dec = (c >= CH_ZERO) && (c <= CH_NINE);
  assign c_low = (c >= CH_ZERO) && (c <= CH_FIVE);

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    fg_code_nxt = fg_code_r;
    bg_code_nxt = bg_code_r;
    flag        = 1'b0;
    act         = ACT_NONE;
    want_apply  = 1'b0;
    unique case (phase_r)
      PH_ESC: begin
        if (c == CH_LBRK) begin
          phase_nxt = PH_BRACKET;
        end else begin
          phase_nxt = PH_AWAIT;
          flag      = 1'b1;
        end
      end
      PH_BRACKET: begin
        if (c_dec) begin
          phase_nxt = PH_DIGIT;
          held_nxt  = c;
        end else begin
          phase_nxt = PH_AWAIT;
          flag      = 1'b1;
        end
      end
      PH_DIGIT: begin
        priority if (held_r == CH_TWO && c == CH_J) begin
          act       = ACT_CLEAR;
          phase_nxt = PH_AWAIT;
        end else if (held_r == CH_ZERO && c == CH_M) begin
          fg_code_nxt = CODE_RESET;
          bg_code_nxt = CODE_RESET;
          want_apply  = 1'b1;
          phase_nxt   = PH_AWAIT;
        end else if (held_r == CH_THREE && c_low) begin
          fg_code_nxt = c[CODE_W-1:0];
        end else if (c == CH_SEMI) begin
          phase_nxt = PH_BACKGROUND;
          held_nxt  = CH_NULL;
        end else if (c == CH_M) begin
          bg_code_nxt = CODE_RESET;
          want_apply  = 1'b1;
          phase_nxt   = PH_AWAIT;
        end else begin
          phase_nxt = PH_AWAIT;
        end
      end
      PH_BACKGROUND: begin
        priority if (held_r == CH_NULL && c_dec) begin
          held_nxt = c;
        end else if (held_r == CH_FOUR && c_low) begin
          bg_code_nxt = c[CODE_W-1:0];
        end else if (c == CH_M) begin
          want_apply = 1'b1;
          phase_nxt  = PH_AWAIT;
        end else begin
          phase_nxt = PH_AWAIT;
        end
      end
      default: begin
        if (c == CH_ESC) begin
          phase_nxt = PH_ESC;
          flag      = 1'b1;
        end else begin
          phase_nxt = PH_AWAIT;
        end
      end
    endcase

    fg_rgb = '0;
    bg_rgb = '0;
    if (want_apply && fg_code_nxt != CODE_NONE && bg_code_nxt != CODE_NONE) begin
      act    = ACT_APPLY;
      fg_rgb = code_to_rgb(fg_code_nxt, def_fg_r);
      bg_rgb = code_to_rgb(bg_code_nxt, def_bg_r);
    end
    out_data_nxt = {{(OUT_W-OUT_BITS){1'b0}}, bg_rgb, fg_rgb, act, flag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_AWAIT;
      held_r      <= CH_NULL;
      fg_code_r   <= CODE_NONE;
      bg_code_r   <= CODE_NONE;
      def_fg_r    <= RST_DEFAULT_FG;
      def_bg_r    <= RST_DEFAULT_BG;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_DEFAULT_BG) begin
          def_bg_r <= cfg_pwdata[RGB_W-1:0];
        end else begin
          def_fg_r <= cfg_pwdata[RGB_W-1:0];
        end
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        held_r      <= held_nxt;
        fg_code_r   <= fg_code_nxt;
        bg_code_r   <= bg_code_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  a_act_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[2:1] != 2'd3)
    else $error("illegal action code");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |-> out_data_r[2:1] == ACT_NONE)
    else $error("escape flag with an action");

  a_rgb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[2:1] != ACT_APPLY |-> out_data_r[OUT_BITS-1:3] == '0)
    else $error("rgb nonzero without apply");

  a_apply_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[2:1] == ACT_APPLY |->
      fg_code_r != CODE_NONE && bg_code_r != CODE_NONE)
    else $error("apply while a color is none");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(phase_r))
    else $error("parser advanced during stall");

endmodule
